### design/pca_pkg.sv
// Package for the period candle aggregator: field widths, codes, calendar table
// and reciprocal constants. No dependencies.
package pca_pkg;

   localparam int COUNT_BITS_DEFAULT  = 20;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int YEAR_BITS   = 14;
   localparam int MONTH_BITS  = 4;
   localparam int DAY_BITS    = 5;
   localparam int PERIOD_BITS = 6;
   localparam int DOY_BITS    = 9;
   localparam int QUOT_BITS   = 8;   // year / 100 for years below 2^14

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_GRANULARITY = 1'b0;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   localparam logic [1:0] GRAN_YEARLY  = 2'd0;
   localparam logic [1:0] GRAN_MONTHLY = 2'd1;
   localparam logic [1:0] GRAN_WEEKLY  = 2'd2;

   // Days before the first of each month in a common year
   localparam logic [DOY_BITS-1:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // y / 100 = (y * 5243) >> 19, exact for y < 2^14
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_PROD  = YEAR_BITS + 13;
   // x / 7 = (x * 293) >> 11, exact for x < 682
   localparam int DIV7_MUL   = 293;
   localparam int DIV7_SHIFT = 11;
   localparam int DIV7_PROD  = DOY_BITS + 9;

   typedef struct packed {
      logic step_quot;
      logic step_doy;
      logic step_period;
   } pca_key_ctrl_type;

endpackage

### design/pca_period_key.sv
// Three-step grouping key unit: year / 100 for the leap test, day of year,
// then month or week number (zero when yearly). Uses pca_pkg.
module pca_period_key (
   input  logic                                clock,
   input  pca_pkg::pca_key_ctrl_type           ctrl,
   input  logic [1:0]                          granularity,
   input  logic [pca_pkg::YEAR_BITS-1:0]       year,
   input  logic [pca_pkg::MONTH_BITS-1:0]      month,
   input  logic [pca_pkg::DAY_BITS-1:0]        day,
   output logic [pca_pkg::PERIOD_BITS-1:0]     period
);

   logic [pca_pkg::DIV100_PROD-1:0]  quot_prod;
   logic [pca_pkg::QUOT_BITS-1:0]    quot_ff, quot_in;
   logic [pca_pkg::MONTH_BITS-1:0]   month_ff, month_in;
   logic [pca_pkg::YEAR_BITS-1:0]    rem100;
   logic                             leap;
   logic [pca_pkg::DOY_BITS-1:0]     doy_ff, doy_in;
   logic [pca_pkg::DOY_BITS-1:0]     doy_m1;
   logic [pca_pkg::DIV7_PROD-1:0]    week_prod;
   logic [pca_pkg::PERIOD_BITS-1:0]  week;
   logic [pca_pkg::PERIOD_BITS-1:0]  period_ff, period_in;

   // step one: quotient by 100, clamped month
   always_comb begin
      quot_prod = pca_pkg::DIV100_PROD'(year) * pca_pkg::DIV100_PROD'(pca_pkg::DIV100_MUL);
      quot_in   = pca_pkg::QUOT_BITS'(quot_prod >> pca_pkg::DIV100_SHIFT);
      if (month == '0) begin
         month_in = pca_pkg::MONTH_BITS'(1);
      end else if (month > pca_pkg::MONTH_BITS'(12)) begin
         month_in = pca_pkg::MONTH_BITS'(12);
      end else begin
         month_in = month;
      end
   end

   // step two: leap test and day of year
   always_comb begin
      rem100 = year - pca_pkg::YEAR_BITS'(pca_pkg::YEAR_BITS'(quot_ff) * pca_pkg::YEAR_BITS'(100));
      leap   = (year[1:0] == 2'b00) && ((rem100 != '0) || (quot_ff[1:0] == 2'b00));
      doy_in = pca_pkg::MONTH_START[month_ff - pca_pkg::MONTH_BITS'(1)]
               + pca_pkg::DOY_BITS'(day)
               + pca_pkg::DOY_BITS'(leap && (month_ff > pca_pkg::MONTH_BITS'(2)));
   end

   // step three: final key
   always_comb begin
      doy_m1    = doy_ff - pca_pkg::DOY_BITS'(1);
      week_prod = pca_pkg::DIV7_PROD'(doy_m1) * pca_pkg::DIV7_PROD'(pca_pkg::DIV7_MUL);
      week      = pca_pkg::PERIOD_BITS'(week_prod >> pca_pkg::DIV7_SHIFT)
                  + pca_pkg::PERIOD_BITS'(1);
      unique case (granularity)
         pca_pkg::GRAN_MONTHLY: begin
            period_in = pca_pkg::PERIOD_BITS'(month_ff);
         end
         pca_pkg::GRAN_WEEKLY: begin
            period_in = (doy_ff == '0) ? pca_pkg::PERIOD_BITS'(1) : week;
         end
         default: begin
            period_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.step_quot) begin
         quot_ff  <= quot_in;
         month_ff <= month_in;
      end
      if (ctrl.step_doy) begin
         doy_ff <= doy_in;
      end
      if (ctrl.step_period) begin
         period_ff <= period_in;
      end
   end

   assign period = period_ff;

endmodule

### design/pca_divider.sv
// Restoring divider, one quotient bit per cycle, signed dividend truncated
// toward zero. Uses no package items.
module pca_divider #(
   parameter int DIVIDEND_BITS = 36,
   parameter int DIVISOR_BITS  = 20,
   parameter int QUOTIENT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]         divisor,
   output logic                            done,
   output logic signed [QUOTIENT_BITS-1:0] quotient
);

   localparam int ITER_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [ITER_BITS-1:0]     iter_ff, iter_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic                     neg_ff, neg_in;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;
   logic [QUOTIENT_BITS-1:0] quo_low;

   always_comb begin
      shifted    = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff       = shifted - {1'b0, divisor_ff};
      fits       = !diff[DIVISOR_BITS];
      busy_in    = busy_ff;
      done_in    = 1'b0;
      iter_in    = iter_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      if (start) begin
         busy_in    = 1'b1;
         iter_in    = ITER_BITS'(DIVIDEND_BITS);
         neg_in     = dividend[DIVIDEND_BITS-1];
         quo_in     = dividend[DIVIDEND_BITS-1]
                      ? (~DIVIDEND_BITS'(dividend) + DIVIDEND_BITS'(1))
                      : DIVIDEND_BITS'(dividend);
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         iter_in = iter_ff - ITER_BITS'(1);
         if (iter_ff == ITER_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

   assign quo_low  = quo_ff[QUOTIENT_BITS-1:0];
   assign quotient = neg_ff ? signed'(-quo_low) : signed'(quo_low);
   assign done     = done_ff;

endmodule

### design/period_candle_aggregator.sv
// Top level of the period candle aggregator: sequencer, period state, output
// register and register port. Uses pca_pkg, pca_period_key and pca_divider.
//
// Usage: dated samples arrive in time order on the req_ channel (valid/ready).
// operation = sample adds the temperature to the open period; a sample whose
// year/period key differs from the open one, or a flush, closes it and one
// candle leaves on the rsp_ channel (valid/ready). The grouping period is set
// by the granularity register (byte address 0) on the csr_ port; the user must
// set it only while idle, as the block does not enforce this. One request at a
// time: req_ready is high only while the sequencer is idle. A sample that
// closes nothing passes three key steps and an update step before req_ready is
// high again; no new sample is taken before the last is through. A sample that
// closes a period also runs the shared divider and then loads the output
// register; the candle becomes valid as req_ready goes high again. A flush
// skips the key steps; a flush with nothing open returns to idle, no candle.
// The candle waits in the output register while rsp_ready
// is low; further requests are taken meanwhile, and the sequencer stalls only
// when a second candle is ready before the first has been taken.
// Reset clears the period state, the output valid flag and the granularity
// (yearly); the first candle after reset opens at zero.
module period_candle_aggregator #(
   parameter int COUNT_BITS  = pca_pkg::COUNT_BITS_DEFAULT,
   parameter int SAMPLE_BITS = pca_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [pca_pkg::YEAR_BITS-1:0]        req_sample_year,
   input  logic [pca_pkg::MONTH_BITS-1:0]       req_sample_month,
   input  logic [pca_pkg::DAY_BITS-1:0]         req_sample_day,
   input  logic signed [SAMPLE_BITS-1:0]        req_temperature,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pca_pkg::YEAR_BITS-1:0]        rsp_period_year,
   output logic [pca_pkg::PERIOD_BITS-1:0]      rsp_period_number,
   output logic signed [SAMPLE_BITS-1:0]        rsp_open_value,
   output logic signed [SAMPLE_BITS-1:0]        rsp_high_value,
   output logic signed [SAMPLE_BITS-1:0]        rsp_low_value,
   output logic signed [SAMPLE_BITS-1:0]        rsp_close_value,
   output logic [COUNT_BITS-1:0]                rsp_sample_count,
   output logic                                 rsp_count_saturated,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pca_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [pca_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [pca_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_QUOT   = 7'b0000010,
      ST_DOY    = 7'b0000100,
      ST_PERIOD = 7'b0001000,
      ST_DECIDE = 7'b0010000,
      ST_DIVIDE = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0] granularity_ff, granularity_in;
   logic [pca_pkg::CSR_INDEX_BITS-1:0] csr_index;

   // latched request
   logic                               op_ff, op_in;
   logic [pca_pkg::YEAR_BITS-1:0]      year_ff, year_in;
   logic [pca_pkg::MONTH_BITS-1:0]     month_ff, month_in;
   logic [pca_pkg::DAY_BITS-1:0]       day_ff, day_in;
   logic signed [SAMPLE_BITS-1:0]      temp_ff, temp_in;

   // open period
   logic                               pending_ff, pending_in;
   logic [pca_pkg::YEAR_BITS-1:0]      cur_year_ff, cur_year_in;
   logic [pca_pkg::PERIOD_BITS-1:0]    cur_period_ff, cur_period_in;
   logic signed [SUM_BITS-1:0]         sum_ff, sum_in;
   logic [COUNT_BITS-1:0]              count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0]      max_ff, max_in;
   logic signed [SAMPLE_BITS-1:0]      min_ff, min_in;
   logic                               sat_ff, sat_in;
   logic signed [SAMPLE_BITS-1:0]      last_close_ff, last_close_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pca_pkg::YEAR_BITS-1:0]      rsp_year_ff, rsp_year_in;
   logic [pca_pkg::PERIOD_BITS-1:0]    rsp_number_ff, rsp_number_in;
   logic signed [SAMPLE_BITS-1:0]      rsp_open_ff, rsp_open_in;
   logic signed [SAMPLE_BITS-1:0]      rsp_high_ff, rsp_high_in;
   logic signed [SAMPLE_BITS-1:0]      rsp_low_ff, rsp_low_in;
   logic signed [SAMPLE_BITS-1:0]      rsp_close_ff, rsp_close_in;
   logic [COUNT_BITS-1:0]              rsp_count_ff, rsp_count_in;
   logic                               rsp_sat_ff, rsp_sat_in;

   pca_pkg::pca_key_ctrl_type          key_ctrl;
   logic [pca_pkg::PERIOD_BITS-1:0]    key_period;
   logic                               div_start;
   logic                               div_done;
   logic signed [SAMPLE_BITS-1:0]      div_mean;
   logic                               key_differs;

   pca_period_key u_key (
      .clock       (clock),
      .ctrl        (key_ctrl),
      .granularity (granularity_ff),
      .year        (year_ff),
      .month       (month_ff),
      .day         (day_ff),
      .period      (key_period)
   );

   pca_divider #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (COUNT_BITS),
      .QUOTIENT_BITS (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_mean)
   );

   // register port
   assign csr_index  = csr_paddr[pca_pkg::CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == pca_pkg::REG_GRANULARITY)
                       ? pca_pkg::CSR_DATA_BITS'(granularity_ff) : '0;

   always_comb begin
      granularity_in = granularity_ff;
      if (csr_psel && csr_penable && csr_pwrite
          && (csr_index == pca_pkg::REG_GRANULARITY)) begin
         granularity_in = csr_pwdata[1:0];
      end
   end

   assign key_differs = (year_ff != cur_year_ff) || (key_period != cur_period_ff);

   always_comb begin
      state_in      = state_ff;
      key_ctrl      = '0;
      div_start     = 1'b0;
      op_in         = op_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      temp_in       = temp_ff;
      pending_in    = pending_ff;
      cur_year_in   = cur_year_ff;
      cur_period_in = cur_period_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      sat_in        = sat_ff;
      last_close_in = last_close_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_number_in = rsp_number_ff;
      rsp_open_in   = rsp_open_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_close_in  = rsp_close_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_sat_in    = rsp_sat_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               year_in  = req_sample_year;
               month_in = req_sample_month;
               day_in   = req_sample_day;
               temp_in  = req_temperature;
               state_in = (req_operation == pca_pkg::OP_FLUSH) ? ST_DECIDE : ST_QUOT;
            end
         end
         ST_QUOT: begin
            key_ctrl.step_quot = 1'b1;
            state_in = ST_DOY;
         end
         ST_DOY: begin
            key_ctrl.step_doy = 1'b1;
            state_in = ST_PERIOD;
         end
         ST_PERIOD: begin
            key_ctrl.step_period = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (op_ff == pca_pkg::OP_FLUSH) begin
               if (pending_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (pending_ff && key_differs) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else if (!pending_ff) begin
               pending_in    = 1'b1;
               cur_year_in   = year_ff;
               cur_period_in = key_period;
               sum_in        = SUM_BITS'(temp_ff);
               count_in      = COUNT_BITS'(1);
               max_in        = temp_ff;
               min_in        = temp_ff;
               sat_in        = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               if (temp_ff > max_ff) begin
                  max_in = temp_ff;
               end
               if (temp_ff < min_ff) begin
                  min_in = temp_ff;
               end
               if (count_ff == COUNT_MAX) begin
                  sat_in = 1'b1;
               end else begin
                  sum_in   = sum_ff + SUM_BITS'(temp_ff);
                  count_in = count_ff + COUNT_BITS'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_year_in   = cur_year_ff;
               rsp_number_in = cur_period_ff;
               rsp_open_in   = last_close_ff;
               rsp_high_in   = max_ff;
               rsp_low_in    = min_ff;
               rsp_close_in  = div_mean;
               rsp_count_in  = count_ff;
               rsp_sat_in    = sat_ff;
               last_close_in = div_mean;
               pending_in    = 1'b0;
               // a sample that closed the period opens the next one
               if (op_ff == pca_pkg::OP_SAMPLE) begin
                  pending_in    = 1'b1;
                  cur_year_in   = year_ff;
                  cur_period_in = key_period;
                  sum_in        = SUM_BITS'(temp_ff);
                  count_in      = COUNT_BITS'(1);
                  max_in        = temp_ff;
                  min_in        = temp_ff;
                  sat_in        = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         granularity_ff <= pca_pkg::GRAN_YEARLY;
         pending_ff     <= 1'b0;
         cur_year_ff    <= '0;
         cur_period_ff  <= '0;
         sum_ff         <= '0;
         count_ff       <= '0;
         max_ff         <= '0;
         min_ff         <= '0;
         sat_ff         <= 1'b0;
         last_close_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         granularity_ff <= granularity_in;
         pending_ff     <= pending_in;
         cur_year_ff    <= cur_year_in;
         cur_period_ff  <= cur_period_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         max_ff         <= max_in;
         min_ff         <= min_in;
         sat_ff         <= sat_in;
         last_close_ff  <= last_close_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      year_ff       <= year_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      temp_ff       <= temp_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_number_ff <= rsp_number_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_close_ff  <= rsp_close_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_period_year     = rsp_year_ff;
   assign rsp_period_number   = rsp_number_ff;
   assign rsp_open_value      = rsp_open_ff;
   assign rsp_high_value      = rsp_high_ff;
   assign rsp_low_value       = rsp_low_ff;
   assign rsp_close_value     = rsp_close_ff;
   assign rsp_sample_count    = rsp_count_ff;
   assign rsp_count_saturated = rsp_sat_ff;

endmodule
